// ----- src/pli_pkg.sv -----
`default_nettype none

package pli_pkg;

    // Built size of the list
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 16;

    // Port field widths
    localparam int MODE_W = 2;
    localparam int POS_W  = 8;
    localparam int VAL_W  = 16;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;
    localparam int ELEM_W = 16;
    localparam int CAP_W  = 5;

    // Internal widths derived from the depth
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAPC_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int POSC_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_DUMP   = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] pos0;
        logic [CNT_W-1:0] cnt;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- src/pli_ifs.sv -----
`default_nettype none

interface pli_req_if;
    logic                       valid;
    logic                       ready;
    logic [pli_pkg::MODE_W-1:0] mode;
    logic [pli_pkg::POS_W-1:0]  position;
    logic [pli_pkg::VAL_W-1:0]  value;

    modport source (output valid, mode, position, value, input ready);
    modport sink   (input valid, mode, position, value, output ready);
endinterface

interface pli_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [pli_pkg::STAT_W-1:0] status;
    logic [pli_pkg::LEN_W-1:0]  length;
    logic [pli_pkg::ELEM_W-1:0] element;
    logic                       last;

    modport source (output valid, status, length, element, last, input ready);
    modport sink   (input valid, status, length, element, last, output ready);
endinterface

interface pli_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [pli_pkg::CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- src/pli_cell.sv -----
`default_nettype none

module pli_cell (
    input  wire logic                           clk,
    input  wire logic [pli_pkg::IDX_W-1:0]      idx,
    input  wire pli_pkg::cell_cmd_t             cmd,
    input  wire logic [pli_pkg::DATA_WIDTH-1:0] new_value,
    input  wire logic [pli_pkg::DATA_WIDTH-1:0] left_data,
    input  wire logic [pli_pkg::DATA_WIDTH-1:0] right_data,
    input  wire logic [pli_pkg::DATA_WIDTH-1:0] head_data,
    output logic      [pli_pkg::DATA_WIDTH-1:0] data
);

    logic [pli_pkg::DATA_WIDTH-1:0] data_reg;
    logic [pli_pkg::DATA_WIDTH-1:0] data_next;
    logic [pli_pkg::CNT_W-1:0]      my_idx;
    logic [pli_pkg::CNT_W-1:0]      my_pos;

    assign my_idx = pli_pkg::CNT_W'(idx);
    assign my_pos = pli_pkg::CNT_W'(cmd.pos0);

    // Pick the next entry: own value, a neighbor's, the head, or the new value
    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            pli_pkg::CELL_INS:
            begin
                if (my_idx == my_pos)
                begin
                    data_next = new_value;
                end
                else if (my_idx > my_pos && my_idx <= cmd.cnt)
                begin
                    data_next = left_data;
                end
            end
            pli_pkg::CELL_DEL:
            begin
                if (my_idx >= my_pos && my_idx + 1'b1 < cmd.cnt)
                begin
                    data_next = right_data;
                end
            end
            pli_pkg::CELL_ROT:
            begin
                if (my_idx + 1'b1 < cmd.cnt)
                begin
                    data_next = right_data;
                end
                else if (my_idx + 1'b1 == cmd.cnt)
                begin
                    data_next = head_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Hold the entry; contents are undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- src/pli_chain.sv -----
`default_nettype none

module pli_chain (
    input  wire logic                           clk,
    input  wire pli_pkg::cell_cmd_t             cmd,
    input  wire logic [pli_pkg::DATA_WIDTH-1:0] new_value,
    output logic      [pli_pkg::DATA_WIDTH-1:0] head
);

    logic [pli_pkg::DATA_WIDTH-1:0] cell_data [pli_pkg::DEPTH];

    // Build the row; each cell sees its two neighbors and the head
    for (genvar i = 0; i < pli_pkg::DEPTH; i++)
    begin : g_cell
        logic [pli_pkg::DATA_WIDTH-1:0] left_d;
        logic [pli_pkg::DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == pli_pkg::DEPTH - 1)
        begin : g_end
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        pli_cell u_cell (
            .clk        (clk),
            .idx        (pli_pkg::IDX_W'(i)),
            .cmd        (cmd),
            .new_value  (new_value),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

`default_nettype wire

// ----- src/positional_list_insert_delete.sv -----
`default_nettype none

// Channel  Dir  Payload                          Handshake
// req      in   mode, position, value            valid/ready
// rsp      out  status, length, element, last    valid/ready
// cfg      in   data (capacity)                  valid/ready, ready always high
//
// Insert, delete and unknown modes act on the cell chain and give one
// response. A dump gives one response per entry, one a cycle while rsp is not
// stalled, by rotating the chain through its head cell. A new request is taken
// when no dump runs and the response register is free or being emptied. rsp
// stalls hold the response and the chain. Reset clears the length and sets
// capacity to 16.
module positional_list_insert_delete (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pli_req_if.sink    req,
    pli_rsp_if.source  rsp,
    pli_cfg_if.sink    cfg
);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t                         state_reg, state_next;
    logic [pli_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [pli_pkg::CNT_W-1:0]      dump_idx_reg, dump_idx_next;
    logic [pli_pkg::CAP_W-1:0]      cap_reg;
    logic                           rsp_valid_reg, rsp_valid_next;
    pli_pkg::status_t               rsp_status_reg, rsp_status_next;
    logic [pli_pkg::LEN_W-1:0]      rsp_length_reg, rsp_length_next;
    logic [pli_pkg::ELEM_W-1:0]     rsp_element_reg, rsp_element_next;
    logic                           rsp_last_reg, rsp_last_next;

    pli_pkg::cell_cmd_t             cmd;
    logic [pli_pkg::DATA_WIDTH-1:0] head;
    logic [pli_pkg::DATA_WIDTH-1:0] new_value;
    logic                           slot_free;
    logic                           req_fire;
    logic                           is_full;
    logic [pli_pkg::POSC_W-1:0]     pos_c;
    logic [pli_pkg::POSC_W-1:0]     cnt_c;
    pli_pkg::mode_t                 req_mode;

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && slot_free;
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign req_mode  = pli_pkg::mode_t'(req.mode);
    assign new_value = pli_pkg::DATA_WIDTH'(req.value);

    assign pos_c = pli_pkg::POSC_W'(req.position);
    assign cnt_c = pli_pkg::POSC_W'(count_reg);
    assign is_full = (pli_pkg::CAPC_W'(count_reg) >= pli_pkg::CAPC_W'(cap_reg))
                  || (count_reg >= pli_pkg::CNT_W'(pli_pkg::DEPTH));

    // Decode the request, drive the chain and form the response
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        dump_idx_next    = dump_idx_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_status_next  = rsp_status_reg;
        rsp_length_next  = rsp_length_reg;
        rsp_element_next = rsp_element_reg;
        rsp_last_next    = rsp_last_reg;
        cmd.op           = pli_pkg::CELL_HOLD;
        cmd.pos0         = '0;
        cmd.cnt          = count_reg;

        if (state_reg == ST_DUMP)
        begin
            // Emit the head entry and rotate the chain by one
            if (slot_free)
            begin
                cmd.op           = pli_pkg::CELL_ROT;
                rsp_valid_next   = 1'b1;
                rsp_status_next  = pli_pkg::STAT_OK;
                rsp_length_next  = pli_pkg::LEN_W'(count_reg);
                rsp_element_next = pli_pkg::ELEM_W'(head);
                rsp_last_next    = (dump_idx_reg + 1'b1 == count_reg);
                dump_idx_next    = dump_idx_reg + 1'b1;
                if (dump_idx_reg + 1'b1 == count_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
        end
        else if (req_fire)
        begin
            rsp_valid_next   = 1'b1;
            rsp_status_next  = pli_pkg::STAT_OK;
            rsp_element_next = '0;
            rsp_last_next    = 1'b1;
            case (req_mode)
                pli_pkg::MODE_INSERT:
                begin
                    if (is_full)
                    begin
                        rsp_status_next = pli_pkg::STAT_FULL;
                    end
                    else if (req.position == '0)
                    begin
                        rsp_status_next = pli_pkg::STAT_BADPOS;
                    end
                    else
                    begin
                        cmd.op     = pli_pkg::CELL_INS;
                        cmd.pos0   = (pos_c > cnt_c) ? pli_pkg::IDX_W'(count_reg)
                                                     : pli_pkg::IDX_W'(pos_c - 1'b1);
                        count_next = count_reg + 1'b1;
                    end
                end
                pli_pkg::MODE_DELETE:
                begin
                    if (count_reg == '0)
                    begin
                        rsp_status_next = pli_pkg::STAT_EMPTY;
                    end
                    else if (req.position == '0 || pos_c > cnt_c)
                    begin
                        rsp_status_next = pli_pkg::STAT_BADPOS;
                    end
                    else
                    begin
                        cmd.op     = pli_pkg::CELL_DEL;
                        cmd.pos0   = pli_pkg::IDX_W'(pos_c - 1'b1);
                        count_next = count_reg - 1'b1;
                    end
                end
                pli_pkg::MODE_DUMP:
                begin
                    if (count_reg == '0)
                    begin
                        rsp_status_next = pli_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        // Responses come from the dump sequence instead
                        rsp_valid_next = 1'b0;
                        dump_idx_next  = '0;
                        state_next     = ST_DUMP;
                    end
                end
                default:
                begin
                    rsp_status_next = pli_pkg::STAT_OK;
                end
            endcase
            rsp_length_next = pli_pkg::LEN_W'(count_next);
        end
    end

    // Hold state, length, capacity and the response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            dump_idx_reg    <= '0;
            cap_reg         <= pli_pkg::CAP_RESET;
            rsp_valid_reg   <= 1'b0;
            rsp_status_reg  <= pli_pkg::STAT_OK;
            rsp_length_reg  <= '0;
            rsp_element_reg <= '0;
            rsp_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            dump_idx_reg    <= dump_idx_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_status_reg  <= rsp_status_next;
            rsp_length_reg  <= rsp_length_next;
            rsp_element_reg <= rsp_element_next;
            rsp_last_reg    <= rsp_last_next;
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.data;
            end
        end
    end

    pli_chain u_chain (
        .clk       (clk),
        .cmd       (cmd),
        .new_value (new_value),
        .head      (head)
    );

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.status  = rsp_status_reg;
    assign rsp.length  = rsp_length_reg;
    assign rsp.element = rsp_element_reg;
    assign rsp.last    = rsp_last_reg;

    // Length never passes the built depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pli_pkg::CNT_W'(pli_pkg::DEPTH))
        else $error("list length above depth");

    // A dump only runs over a non-empty list
    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |-> count_reg != '0)
        else $error("dump running on empty list");

    // A request other than a non-empty dump yields a response next cycle
    a_req_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && !(req_mode == pli_pkg::MODE_DUMP && count_reg != '0)
        |=> rsp_valid_reg && rsp_last_reg)
        else $error("missing response to request");

    // A successful insert grows the list by one
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_mode == pli_pkg::MODE_INSERT && !is_full && req.position != '0
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow list");

endmodule

`default_nettype wire

// ----- sim/list_response_checker.sv -----
`timescale 1ns / 1ps

module list_response_checker
    import pli_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pli_req_if   req,
    pli_rsp_if   rsp,
    pli_cfg_if   cfg,
    output int   pending,
    output int   mismatches,
    output int   rsp_total
);

    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   length;
        logic [ELEM_W-1:0]  element;
        logic               last;
    } list_rsp_t;

    // Shadow copy of the list and its capacity register
    logic [DATA_WIDTH-1:0] list_vals [DEPTH];
    int                    list_len;
    logic [CAP_W-1:0]      list_cap;

    list_rsp_t expected_rsps [$];
    int        fail_cnt;
    int        seen_cnt;

    initial begin
        fail_cnt = 0;
        seen_cnt = 0;
        list_len = 0;
        list_cap = CAP_RESET;
    end

    task automatic push_rsp(status_t st, logic [ELEM_W-1:0] elem, logic lst);
        list_rsp_t r;
        r.status  = st;
        r.length  = LEN_W'(list_len);
        r.element = elem;
        r.last    = lst;
        expected_rsps.push_back(r);
    endtask

    // Apply one request to the shadow list and queue the responses it causes
    task automatic predict_request(mode_t op, logic [POS_W-1:0] pos,
                                   logic [VAL_W-1:0] val);
        int eff_cap;
        int p;
        int i;
        eff_cap = (list_cap > DEPTH) ? DEPTH : int'(list_cap);
        case (op)
            MODE_INSERT:
            begin
                if (list_len >= eff_cap)
                begin
                    push_rsp(STAT_FULL, '0, 1'b1);
                end
                else if (pos == 0)
                begin
                    push_rsp(STAT_BADPOS, '0, 1'b1);
                end
                else
                begin
                    // Position past the end appends
                    p = (int'(pos) > list_len) ? list_len + 1 : int'(pos);
                    for (i = list_len; i >= p; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[p-1] = val[DATA_WIDTH-1:0];
                    list_len++;
                    push_rsp(STAT_OK, '0, 1'b1);
                end
            end
            MODE_DELETE:
            begin
                if (list_len == 0)
                begin
                    push_rsp(STAT_EMPTY, '0, 1'b1);
                end
                else if (pos == 0 || int'(pos) > list_len)
                begin
                    push_rsp(STAT_BADPOS, '0, 1'b1);
                end
                else
                begin
                    for (i = int'(pos) - 1; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                    push_rsp(STAT_OK, '0, 1'b1);
                end
            end
            MODE_DUMP:
            begin
                if (list_len == 0)
                    push_rsp(STAT_EMPTY, '0, 1'b1);
                else
                    for (i = 0; i < list_len; i++)
                        push_rsp(STAT_OK, ELEM_W'(list_vals[i]), i == list_len - 1);
            end
            default:
            begin
                push_rsp(STAT_OK, '0, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, field, want, want, got, got);
        end
    endtask

    // Compare each accepted response with the oldest expectation
    task automatic check_response();
        list_rsp_t want;
        seen_cnt++;
        if (expected_rsps.size() == 0)
        begin
            fail_cnt++;
            $display("%0t: unexpected response, expected none, actual status %0d",
                     $time, rsp.status);
            $display("%0t:   length %0d element 0x%0h last %0d",
                     $time, rsp.length, rsp.element, rsp.last);
        end
        else
        begin
            want = expected_rsps.pop_front();
            check_field("status", want.status, rsp.status);
            check_field("length", want.length, rsp.length);
            check_field("element", want.element, rsp.element);
            check_field("last", want.last, rsp.last);
        end
    endtask

    // Watch the three channels; responses are checked before new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_len = 0;
            list_cap = CAP_RESET;
            expected_rsps.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_response();
            if (cfg.valid && cfg.ready)
                list_cap = cfg.data;
            if (req.valid && req.ready)
                predict_request(mode_t'(req.mode), req.position, req.value);
            pending <= expected_rsps.size();
        end
        mismatches <= fail_cnt;
        rsp_total  <= seen_cnt;
    end

endmodule

// ----- sim/positional_list_insert_delete_tb.sv -----
`timescale 1ns / 1ps

module positional_list_insert_delete_tb;

    import pli_pkg::*;

    logic clk;
    logic rst_n;
    logic hold_req;
    logic quiet;
    int   pending;
    int   mismatches;
    int   rsp_total;
    int   sent;
    int   cap_writes;

    pli_req_if req_ch ();
    pli_rsp_if rsp_ch ();
    pli_cfg_if cfg_ch ();

    positional_list_insert_delete dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    list_response_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .pending    (pending),
        .mismatches (mismatches),
        .rsp_total  (rsp_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #(20_000_000);
        $display("timeout with %0d responses still expected", pending);
        $display("simulation failed");
        $finish;
    end

    // Response side: random stall bursts, one long hold-off on request
    initial
    begin : rsp_pacing
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                stall_left = 300;
                hold_done  = 1'b1;
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 18);
            end
        end
    end

    // Offer one request and hold it until taken; optionally drop valid for a gap
    task automatic push_request(mode_t op, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] val, bit allow_gap);
        req_ch.mode     <= op;
        req_ch.position <= pos;
        req_ch.value    <= val;
        req_ch.valid    <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent++;
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected response has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_ch.data  <= cap;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cap_writes++;
    endtask

    // Random requests, biased toward growing or shrinking the list
    task automatic run_phase(int n, bit filling, bit gaps);
        int          k;
        int          r;
        mode_t       op;
        logic [POS_W-1:0] pos;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 19);
            if (r == 19)
                op = MODE_NOP;
            else if (r >= 16)
                op = MODE_DUMP;
            else if (filling)
                op = (r < 12) ? MODE_INSERT : MODE_DELETE;
            else
                op = (r < 5) ? MODE_INSERT : MODE_DELETE;
            r = $urandom_range(0, 9);
            if (r == 0)
                pos = '0;
            else if (r == 1)
                pos = POS_W'($urandom_range(0, 255));
            else
                pos = POS_W'($urandom_range(1, 18));
            push_request(op, pos, VAL_W'($urandom_range(0, 65535)), gaps);
        end
    endtask

    initial
    begin : stimulus
        sent       = 0;
        cap_writes = 0;
        rst_n           <= 1'b0;
        hold_req        <= 1'b0;
        quiet           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.mode     <= MODE_INSERT;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list, bad positions, front, middle and append inserts
        push_request(MODE_DUMP,   8'd0,   16'h0000, 1'b0);
        push_request(MODE_DELETE, 8'd1,   16'h0000, 1'b0);
        push_request(MODE_INSERT, 8'd0,   16'h5555, 1'b0);
        push_request(MODE_INSERT, 8'd1,   16'hFFFF, 1'b0);
        push_request(MODE_INSERT, 8'd255, 16'h0000, 1'b0);
        push_request(MODE_INSERT, 8'd1,   16'h1234, 1'b0);
        push_request(MODE_INSERT, 8'd2,   16'hA5A5, 1'b0);
        push_request(MODE_DUMP,   8'd0,   16'h0000, 1'b0);
        push_request(MODE_DELETE, 8'd0,   16'h0000, 1'b0);
        push_request(MODE_DELETE, 8'd5,   16'h0000, 1'b0);
        push_request(MODE_DELETE, 8'd255, 16'h0000, 1'b0);
        push_request(MODE_DELETE, 8'd2,   16'h0000, 1'b0);
        push_request(MODE_NOP,    8'd255, 16'hFFFF, 1'b0);
        push_request(MODE_DUMP,   8'd0,   16'h0000, 1'b0);

        // Capacity below the current length: inserts refused, deletes still work
        set_capacity(5'd2);
        push_request(MODE_INSERT, 8'd1,   16'h0F0F, 1'b0);
        push_request(MODE_DELETE, 8'd1,   16'h0000, 1'b0);
        push_request(MODE_DUMP,   8'd0,   16'h0000, 1'b0);
        push_request(MODE_INSERT, 8'd3,   16'hF0F0, 1'b0);

        // Zero capacity refuses every insert
        set_capacity(5'd0);
        push_request(MODE_INSERT, 8'd1,   16'h00FF, 1'b0);
        push_request(MODE_DELETE, 8'd1,   16'h0000, 1'b0);

        // Random phases across capacity settings, above the depth included
        set_capacity(5'd31);
        run_phase(56, 1'b1, 1'b0);
        set_capacity(5'd16);
        hold_req <= 1'b1;
        run_phase(56, 1'b1, 1'b1);
        set_capacity(5'd1);
        run_phase(56, 1'b1, 1'b1);
        set_capacity(5'd7);
        run_phase(56, 1'b0, 1'b0);
        set_capacity(5'd17);
        run_phase(28, 1'b1, 1'b1);
        wait_drained();
        run_phase(28, 1'b1, 1'b1);
        set_capacity(5'd0);
        run_phase(56, 1'b0, 1'b0);
        set_capacity(5'd3);
        run_phase(56, 1'b1, 1'b1);

        // Final stretch runs without any idling
        set_capacity(5'd16);
        quiet <= 1'b1;
        run_phase(56, 1'b0, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);
        $display("%0d requests of every mode sent over %0d capacity settings,",
                 sent, cap_writes + 1);
        $display("%0d responses compared, including full, empty and bad position",
                 rsp_total);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
